/* rtl/core/itw_pkg.sv */
// Package for the integer-to-word-tokens unit: widths, word codes,
// sequencer state types and the status struct between the converter and the sequencer.
// No dependencies.
package itw_pkg;

  localparam int VALUE_W    = 31;
  localparam int CODE_W     = 5;
  localparam int NUM_DIGITS = 10;
  localparam int BCD_W      = 4 * NUM_DIGITS;
  localparam int CNT_W      = $clog2(VALUE_W + 1);

  // Word codes
  localparam logic [CODE_W-1:0] WC_ZERO       = 5'd0;
  localparam logic [CODE_W-1:0] WC_TEEN_BASE  = 5'd10;
  localparam logic [CODE_W-1:0] WC_TENS_BASE  = 5'd18;
  localparam logic [CODE_W-1:0] WC_HUNDRED    = 5'd28;
  localparam logic [CODE_W-1:0] WC_SCALE_BASE = 5'd28;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT,
    ST_ZERO
  } itw_state_t;

  typedef enum logic [2:0] {
    SP_HUND,
    SP_HWORD,
    SP_TENS,
    SP_ONES,
    SP_SCALE
  } itw_step_t;

  typedef struct packed {
    logic busy;
    logic done;
  } itw_conv_stat_t;

endpackage

/* rtl/core/itw_if.sv */
// Handshake channels of the integer-to-word-tokens unit.
// Depends on itw_pkg for payload widths.
interface itw_num_if;
  logic                        valid;
  logic                        ready;
  logic [itw_pkg::VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface itw_word_if;
  logic                       valid;
  logic                       ready;
  logic [itw_pkg::CODE_W-1:0] word_code;
  logic                       last_word;

  modport source (output valid, output word_code, output last_word, input ready);
  modport sink   (input valid, input word_code, input last_word, output ready);
endinterface

/* rtl/core/integer_to_word_tokens_unit.sv */
// Top level of the integer-to-word-tokens unit.
// Depends on itw_pkg, itw_if, itw_bcd_conv and itw_word_seq.
//
// Spells a 31-bit unsigned number as English word codes, most significant
// word first, one code per transfer on the words channel, last_word set on
// the final one. Codes: 0 Zero, 1-9 One..Nine, 10-19 Ten..Nineteen,
// 20-27 Twenty..Ninety, 28 Hundred, 29 Thousand, 30 Million, 31 Billion.
// The value is first turned into ten BCD digits by a shift-and-add-3 unit
// that takes one input bit per cycle, then a sequencer walks the four
// three-digit groups, five steps each (hundreds, Hundred, tens or teen,
// ones, scale), emitting at most one word per step into an output
// register and stopping at the step that makes the last word. Steps that
// make no word are walked as well. The sequencer takes one step for Zero
// and up to nineteen when the last word is the ones word of the lowest
// group; a stalled words channel holds the sequencer.
// num.ready is high only while the sequencer is idle; the final word may
// still be waiting in the output register when the next number is taken.
module integer_to_word_tokens_unit (
  input  logic       clk,
  input  logic       rst,
  itw_num_if.sink    num,
  itw_word_if.source words
);
  import itw_pkg::*;

  logic                 idle;
  logic                 start;
  logic [BCD_W-1:0]     digits;
  itw_conv_stat_t       cstat;

  // a new number is taken only while the sequencer is idle
  assign num.ready = idle;
  assign start     = num.valid && idle;

  itw_bcd_conv u_conv (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .value  (num.value),
    .digits (digits),
    .stat   (cstat)
  );

  itw_word_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .stat   (cstat),
    .digits (digits),
    .idle   (idle),
    .words  (words)
  );

endmodule

/* rtl/core/itw_bcd_conv.sv */
// Binary to BCD converter, shift-and-add-3, one input bit per cycle.
// Depends on itw_pkg.
module itw_bcd_conv (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [itw_pkg::VALUE_W-1:0]    value,
  output logic [itw_pkg::BCD_W-1:0]      digits,
  output itw_pkg::itw_conv_stat_t        stat
);
  import itw_pkg::*;

  logic [VALUE_W-1:0] bin;
  logic [BCD_W-1:0]   bcd;
  logic [BCD_W-1:0]   adj;
  logic [CNT_W-1:0]   cnt;
  logic               busy;
  logic               done;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(VALUE_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      bin <= value;
      bcd <= '0;
    end else if (busy) begin
      bcd <= {adj[BCD_W-2:0], bin[VALUE_W-1]};
      bin <= {bin[VALUE_W-2:0], 1'b0};
    end
  end

  assign digits    = bcd;
  assign stat.busy = busy;
  assign stat.done = done;

  a_start_busy: assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("converter did not start");
  a_busy_cnt: assert property (@(posedge clk) disable iff (rst) busy |-> cnt != '0)
    else $error("converter busy with empty count");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) && !busy))
    else $error("done without a finished pass");

endmodule

/* rtl/core/itw_word_seq.sv */
// Word sequencer: walks the decimal groups and drives the registered word channel.
// Depends on itw_pkg and itw_if.
module itw_word_seq (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  itw_pkg::itw_conv_stat_t   stat,
  input  logic [itw_pkg::BCD_W-1:0] digits,
  output logic                      idle,
  itw_word_if.source                words
);
  import itw_pkg::*;

  itw_state_t       state, state_next;
  itw_step_t        step, step_next;
  logic [1:0]       grp, grp_next;

  logic             oval;
  logic [CODE_W-1:0] ocode;
  logic             olast;
  logic             slot_free;

  logic [47:0]      dig;
  logic [11:0]      gbits;
  logic [47:0]      low_mask;
  logic [3:0]       hd, td, od;
  logic             low_nz, grp_nz, upper;
  logic             emit, more;
  logic [CODE_W-1:0] code;

  assign dig       = {8'd0, digits};
  assign slot_free = !oval || words.ready;

  always_comb begin
    case (grp)
      2'd0:    begin gbits = dig[11:0];  low_mask = 48'h0;            end
      2'd1:    begin gbits = dig[23:12]; low_mask = 48'h0000_0000_0FFF; end
      2'd2:    begin gbits = dig[35:24]; low_mask = 48'h0000_00FF_FFFF; end
      default: begin gbits = dig[47:36]; low_mask = 48'h000F_FFFF_FFFF; end
    endcase
  end

  assign hd     = gbits[11:8];
  assign td     = gbits[7:4];
  assign od     = gbits[3:0];
  assign low_nz = |(dig & low_mask);
  assign grp_nz = |gbits;
  assign upper  = (grp != 2'd0);

  // word for the current step, and whether any word follows it
  always_comb begin
    emit = 1'b0;
    more = 1'b0;
    code = WC_ZERO;
    unique case (step)
      SP_HUND: begin
        emit = (hd != 4'd0);
        code = {1'b0, hd};
        more = 1'b1;
      end
      SP_HWORD: begin
        emit = (hd != 4'd0);
        code = WC_HUNDRED;
        more = (td != 4'd0) || (od != 4'd0) || upper || low_nz;
      end
      SP_TENS: begin
        emit = (td != 4'd0);
        code = (td == 4'd1) ? WC_TEEN_BASE + {1'b0, od} : WC_TENS_BASE + {1'b0, td};
        more = ((td != 4'd1) && (od != 4'd0)) || upper || low_nz;
      end
      SP_ONES: begin
        emit = (od != 4'd0) && (td != 4'd1);
        code = {1'b0, od};
        more = upper || low_nz;
      end
      SP_SCALE: begin
        emit = upper && grp_nz;
        code = WC_SCALE_BASE + {3'b000, grp};
        more = low_nz;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    grp_next   = grp;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        if (stat.done) begin
          step_next  = SP_HUND;
          grp_next   = 2'd3;
          state_next = (|digits) ? ST_EMIT : ST_ZERO;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          if (emit && !more) begin
            state_next = ST_IDLE;
          end else begin
            unique case (step)
              SP_HUND:  step_next = SP_HWORD;
              SP_HWORD: step_next = SP_TENS;
              SP_TENS:  step_next = SP_ONES;
              SP_ONES:  step_next = SP_SCALE;
              SP_SCALE: begin
                step_next = SP_HUND;
                grp_next  = grp - 2'd1;
                if (grp == 2'd0) begin
                  state_next = ST_IDLE;
                end
              end
              default: step_next = SP_HUND;
            endcase
          end
        end
      end
      ST_ZERO: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= SP_HUND;
      grp   <= 2'd3;
    end else begin
      state <= state_next;
      step  <= step_next;
      grp   <= grp_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      oval <= 1'b0;
    end else if (slot_free) begin
      oval <= ((state == ST_EMIT) && emit) || (state == ST_ZERO);
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free) begin
      if (state == ST_ZERO) begin
        ocode <= WC_ZERO;
        olast <= 1'b1;
      end else begin
        ocode <= code;
        olast <= !more;
      end
    end
  end

  assign idle            = (state == ST_IDLE);
  assign words.valid     = oval;
  assign words.word_code = ocode;
  assign words.last_word = olast;

  a_done_in_conv: assert property (@(posedge clk) disable iff (rst)
    stat.done |-> state == ST_CONV)
    else $error("conversion finished outside the convert state");
  a_zero_word: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ZERO && slot_free) |=> (oval && olast && ocode == WC_ZERO))
    else $error("zero value did not give a single last Zero");
  a_no_conv_emit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> !stat.busy)
    else $error("emitting while converter still busy");

endmodule
